// ----- design/dicp_pkg.sv -----
// Shared types and constants for the dual-channel capture period meter.
package dicp_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned PeriodW = 2 * TimerW;
  localparam int unsigned CfgIdxW = 4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHAN1_ENABLE = 4'd0,
    CFG_CHAN2_ENABLE = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic              overflow_tick;
    logic              cap1_seen;
    logic [TimerW-1:0] cap1_count;
    logic              cap2_seen;
    logic [TimerW-1:0] cap2_count;
  } in_beat_t;

  typedef struct packed {
    logic [PeriodW-1:0] period1;
    logic [PeriodW-1:0] period2;
    logic               period1_valid;
    logic               period2_valid;
  } out_beat_t;

  // Control handed from the top level to one channel slice.
  typedef struct packed {
    logic step;
    logic en;
    logic tick;
    logic cap;
  } chan_ctrl_t;

  // Result of one channel slice after the update of the current beat.
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic               valid;
  } chan_res_t;

endpackage

// ----- design/dicp_if.sv -----
// Valid/ready channel interfaces for event input, result output and configuration.
interface dicp_in_if;
  logic               valid;
  logic               ready;
  dicp_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dicp_out_if;
  logic                valid;
  logic                ready;
  dicp_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dicp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dicp_pkg::CfgIdxW-1:0]   index;
  logic                           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/dicp_chan.sv -----
// One capture channel: wrap counter, last capture, measured period and seen flag.
module dicp_chan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dicp_pkg::chan_ctrl_t          ctrl_i,
  input  logic [dicp_pkg::TimerW-1:0]   count_i,
  output dicp_pkg::chan_res_t           res_o
);

  logic [dicp_pkg::TimerW-1:0]  wraps_q, wraps_d, wraps_inc;
  logic [dicp_pkg::TimerW-1:0]  last_q, last_d;
  logic [dicp_pkg::PeriodW-1:0] span_q, span_d;
  logic                         seen_q, seen_d;
  logic                         do_cap;

  always_comb begin
    wraps_inc = ctrl_i.tick ? wraps_q + 1'b1 : wraps_q;
    do_cap    = ctrl_i.en && ctrl_i.cap;
    wraps_d   = wraps_q;
    last_d    = last_q;
    span_d    = span_q;
    seen_d    = seen_q;
    if (ctrl_i.en) begin
      wraps_d = wraps_inc;
    end
    if (do_cap) begin
      // The wrap count forms the upper half of the current timestamp.
      span_d  = {wraps_inc, count_i} - {{dicp_pkg::TimerW{1'b0}}, last_q};
      wraps_d = '0;
      last_d  = count_i;
      seen_d  = 1'b1;
    end
    res_o.valid  = ctrl_i.en && seen_d;
    res_o.period = res_o.valid ? span_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wraps_q <= '0;
      last_q  <= '0;
      span_q  <= '0;
      seen_q  <= 1'b0;
    end else if (ctrl_i.step) begin
      wraps_q <= wraps_d;
      last_q  <= last_d;
      span_q  <= span_d;
      seen_q  <= seen_d;
    end
  end

  // A disabled channel keeps its whole state across a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && !ctrl_i.en |=> $stable({wraps_q, last_q, span_q, seen_q}))
    else $error("disabled channel state changed");

  // A capture restarts the wrap count and becomes the new reference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && ctrl_i.en && ctrl_i.cap |=> wraps_q == '0 && last_q == $past(count_i))
    else $error("capture did not update reference");

  // Once a period has been measured it stays measured until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> seen_q)
    else $error("seen flag fell");

endmodule

// ----- design/dual_input_capture_period_core.sv -----
// Top level of the dual-channel input-capture period meter.
//
// The block watches one shared free-running 16-bit timer. Each beat on the
// event input channel describes one timer event: whether the timer wrapped,
// and for each of the two channels whether a capture happened and the count
// it latched. Every accepted event beat yields exactly one result beat that
// carries both channels' latest periods and their valid flags, after this
// event's update. Wraps are applied before captures within one event.
//
// The configuration channel writes the two channel enables; it is always
// ready and is meant to be used only while no event is in flight.
//
// The event is held in an input register, and the channel update then lands
// in the result register. While the receiver takes results, one event is
// accepted every cycle; each channel slice holds a single add and subtract
// between those registers. When the receiver stalls, the result register
// holds its beat and the input register fills; input ready then drops until
// the result is taken.
// Reset clears the enables, all channel state and both pipeline valid flags.
module dual_input_capture_period_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  dicp_in_if.sink       in_ch,
  dicp_out_if.source    out_ch,
  dicp_cfg_if.sink      cfg_ch
);

  logic chan1_en_q, chan2_en_q;

  // Input stage.
  logic               s1_valid_q;
  dicp_pkg::in_beat_t s1_beat_q;
  logic               s1_go;

  // Result stage.
  logic                out_valid_q;
  dicp_pkg::out_beat_t out_beat_q;

  dicp_pkg::chan_ctrl_t ctrl1, ctrl2;
  dicp_pkg::chan_res_t  res1, res2;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan1_en_q <= 1'b0;
      chan2_en_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == dicp_pkg::CFG_CHAN1_ENABLE) begin
        chan1_en_q <= cfg_ch.data;
      end
      if (cfg_ch.index == dicp_pkg::CFG_CHAN2_ENABLE) begin
        chan2_en_q <= cfg_ch.data;
      end
    end
  end

  // The input stage moves on whenever the result register is free or drains.
  assign s1_go       = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_beat_q <= in_ch.data;
    end
  end

  always_comb begin
    ctrl1.step = s1_go;
    ctrl1.en   = chan1_en_q;
    ctrl1.tick = s1_beat_q.overflow_tick;
    ctrl1.cap  = s1_beat_q.cap1_seen;
    ctrl2.step = s1_go;
    ctrl2.en   = chan2_en_q;
    ctrl2.tick = s1_beat_q.overflow_tick;
    ctrl2.cap  = s1_beat_q.cap2_seen;
  end

  dicp_chan u_chan1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl1),
    .count_i (s1_beat_q.cap1_count),
    .res_o   (res1)
  );

  dicp_chan u_chan2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl2),
    .count_i (s1_beat_q.cap2_count),
    .res_o   (res2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ch.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_beat_q.period1       <= res1.period;
      out_beat_q.period2       <= res2.period;
      out_beat_q.period1_valid <= res1.valid;
      out_beat_q.period2_valid <= res2.valid;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_beat_q;

  // A waiting input beat is not lost while the result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q)
    else $error("input stage dropped a beat");

  // Every advance of the input stage loads a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_valid_q)
    else $error("advanced beat missing from result register");

  // A result reporting an invalid channel carries a zero period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_beat_q.period1_valid |-> out_beat_q.period1 == '0)
    else $error("invalid channel one period is nonzero");

endmodule
